/* hw/rtl/iap_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package iap_pkg;

    localparam int VALUE_W      = 64;
    localparam int CHAR_W       = 8;
    localparam int FWIDTH_W     = 6;
    localparam int ROOM_W       = 8;
    localparam int RESULT_LIMIT = 32;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    typedef enum logic [1:0] {
        RADIX_DEC       = 2'd0,
        RADIX_HEX_LOWER = 2'd1,
        RADIX_HEX_UPPER = 2'd2
    } radix_t;

    // One classified request as it waits between front and back.
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic                hex;
        logic                upper;
        logic [CHAR_W-1:0]   pad_char;
        logic [FWIDTH_W-1:0] width;
        logic [ROOM_W-1:0]   room;
    } iap_req_t;

    function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d, logic upper);
        if (d < 4'd10)
            return CHAR_ZERO + {4'b0000, d};
        else if (upper)
            return CHAR_UPPER_A + {4'b0000, d - 4'd10};
        else
            return CHAR_LOWER_A + {4'b0000, d - 4'd10};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/iap_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface iap_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  radix_mode;
    logic        pad_with_zero;
    logic [5:0]  field_width;
    logic [7:0]  room_left;

    modport source (output valid, output value, output radix_mode, output pad_with_zero,
                    output field_width, output room_left, input ready);
    modport sink   (input valid, input value, input radix_mode, input pad_with_zero,
                    input field_width, input room_left, output ready);
endinterface

`default_nettype wire

/* hw/rtl/iap_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface iap_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

`default_nettype wire

/* hw/rtl/iap_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module iap_front #(
    parameter int MAX_FIELD_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    iap_in_if.sink            number,
    output logic              q_valid,
    output iap_pkg::iap_req_t q_req,
    input  logic              q_pop
);
    import iap_pkg::*;

    localparam int WIDTH_CAP = (MAX_FIELD_WIDTH < RESULT_LIMIT) ? MAX_FIELD_WIDTH
                                                                 : RESULT_LIMIT;
    localparam int QDEPTH    = 2;

    iap_req_t    entry_reg [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    iap_req_t    req_class;
    logic        push;

    // Classify the incoming request: radix, pad byte, clamped width.
    always_comb
    begin
        req_class.value = number.value;
        case (radix_t'(number.radix_mode))
            RADIX_DEC:
            begin
                req_class.hex   = 1'b0;
                req_class.upper = 1'b0;
            end
            RADIX_HEX_LOWER:
            begin
                req_class.hex   = 1'b1;
                req_class.upper = 1'b0;
            end
            default:
            begin
                req_class.hex   = 1'b1;
                req_class.upper = 1'b1;
            end
        endcase
        req_class.pad_char = number.pad_with_zero ? CHAR_ZERO : CHAR_SPACE;
        req_class.width    = (number.field_width > FWIDTH_W'(WIDTH_CAP))
                             ? FWIDTH_W'(WIDTH_CAP) : number.field_width;
        req_class.room     = number.room_left;
    end

    assign number.ready = (count_reg != 2'(QDEPTH));
    assign push         = number.valid && number.ready;
    assign q_valid      = (count_reg != 2'd0);
    assign q_req        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= req_class;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count lost a request");

endmodule

`default_nettype wire

/* hw/rtl/iap_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module iap_back #(
    parameter int MAX_DIGITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  iap_pkg::iap_req_t q_req,
    output logic              q_pop,
    iap_out_if.source         text
);
    import iap_pkg::*;

    localparam int DW     = MAX_DIGITS * 4;
    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
    localparam int STEPS  = VALUE_W / 4;
    localparam int STEP_W = $clog2(STEPS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_COUNT = 5'b00100,
        S_PAD   = 5'b01000,
        S_DIGIT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [DW-1:0]       bcd_reg, bcd_next;
    logic [VALUE_W-1:0]  sh_reg, sh_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                ovf_reg, ovf_next;
    logic                upper_reg, upper_next;
    logic [CHAR_W-1:0]   pad_char_reg, pad_char_next;
    logic [FWIDTH_W-1:0] width_reg, width_next;
    logic [ROOM_W-1:0]   room_reg, room_next;
    logic [FWIDTH_W-1:0] pad_left_reg, pad_left_next;
    logic [NDIG_W-1:0]   nout_left_reg, nout_left_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;

    logic [DW-1:0]       dabble;
    logic                spill;
    logic [NDIG_W-1:0]   ndig;
    logic [ROOM_W-1:0]   pad_raw, pad_cnt, room_rest, dig_cnt, ndig_ext, width_ext;
    logic [3:0]          cur_digit;
    logic                adv;

    // Four double-dabble bit steps per cycle on the BCD digit row.
    // Note any bit that leaves the top of the row: the value has more digits.
    always_comb
    begin
        dabble = bcd_reg;
        spill  = 1'b0;
        for (int s = 0; s < 4; s++)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                if (dabble[4*i +: 4] >= 4'd5)
                    dabble[4*i +: 4] = dabble[4*i +: 4] + 4'd3;
            end
            spill  = spill | dabble[DW-1];
            dabble = {dabble[DW-2:0], sh_reg[VALUE_W-1-s]};
        end
    end

    // Digit count: highest nonzero digit, at least one; a value too long
    // for the row keeps every digit of the row.
    always_comb
    begin
        ndig = NDIG_W'(1);
        for (int i = 1; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                ndig = NDIG_W'(i + 1);
        end
        if (ovf_reg)
            ndig = NDIG_W'(MAX_DIGITS);
    end

    // Cut padding first, then digits, against the room left.
    always_comb
    begin
        ndig_ext  = ROOM_W'(ndig);
        width_ext = ROOM_W'(width_reg);
        pad_raw   = (width_ext > ndig_ext) ? width_ext - ndig_ext : '0;
        pad_cnt   = (pad_raw > room_reg) ? room_reg : pad_raw;
        room_rest = room_reg - pad_cnt;
        dig_cnt   = (ndig_ext > room_rest) ? room_rest : ndig_ext;
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign adv       = !out_valid_reg || text.ready;

    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last_char = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        bcd_next       = bcd_reg;
        sh_next        = sh_reg;
        step_next      = step_reg;
        ovf_next       = ovf_reg;
        upper_next     = upper_reg;
        pad_char_next  = pad_char_reg;
        width_next     = width_reg;
        room_next      = room_reg;
        pad_left_next  = pad_left_reg;
        nout_left_next = nout_left_reg;
        idx_next       = idx_reg;
        out_valid_next = adv ? 1'b0 : out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    upper_next    = q_req.upper;
                    pad_char_next = q_req.pad_char;
                    width_next    = q_req.width;
                    room_next     = q_req.room;
                    sh_next       = q_req.value;
                    step_next     = '0;
                    ovf_next      = 1'b0;
                    if (q_req.hex)
                    begin
                        bcd_next   = DW'(q_req.value);
                        state_next = S_COUNT;
                    end
                    else
                    begin
                        bcd_next   = '0;
                        state_next = S_CONV;
                    end
                end
            end
            S_CONV:
            begin
                bcd_next  = dabble;
                ovf_next  = ovf_reg | spill;
                sh_next   = sh_reg << 4;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1))
                    state_next = S_COUNT;
            end
            S_COUNT:
            begin
                pad_left_next  = pad_cnt[FWIDTH_W-1:0];
                nout_left_next = dig_cnt[NDIG_W-1:0];
                idx_next       = IDX_W'(ndig - NDIG_W'(1));
                if (pad_cnt != '0)
                    state_next = S_PAD;
                else if (dig_cnt != '0)
                    state_next = S_DIGIT;
                else
                    state_next = S_IDLE;
            end
            S_PAD:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    char_next      = pad_char_reg;
                    last_next      = (pad_left_reg == FWIDTH_W'(1)) && (nout_left_reg == '0);
                    pad_left_next  = pad_left_reg - FWIDTH_W'(1);
                    if (pad_left_reg == FWIDTH_W'(1))
                        state_next = (nout_left_reg == '0) ? S_IDLE : S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(cur_digit, upper_reg);
                    last_next      = (nout_left_reg == NDIG_W'(1));
                    nout_left_next = nout_left_reg - NDIG_W'(1);
                    idx_next       = idx_reg - IDX_W'(1);
                    if (nout_left_reg == NDIG_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        bcd_reg       <= bcd_next;
        sh_reg        <= sh_next;
        ovf_reg       <= ovf_next;
        upper_reg     <= upper_next;
        pad_char_reg  <= pad_char_next;
        width_reg     <= width_next;
        room_reg      <= room_next;
        pad_left_reg  <= pad_left_next;
        nout_left_reg <= nout_left_next;
        idx_reg       <= idx_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("request popped while busy");

    a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PAD |-> pad_left_reg != '0)
        else $error("pad phase with nothing to pad");

    a_digit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIGIT |-> (nout_left_reg != '0 && nout_left_reg <= ndig))
        else $error("digit phase count out of range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT && adv && nout_left_reg == NDIG_W'(1))
        |=> (state_reg == S_IDLE && text.valid && text.last_char))
        else $error("final digit did not close the request");

endmodule

`default_nettype wire

/* hw/rtl/integer_to_ascii_padded_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Unsigned 64-bit to ASCII converter with padding. Each request on "number"
// carries a value, a radix (decimal, lower-case hex, upper-case hex; code
// three acts as upper-case hex), a pad choice ('0' or space), a minimum
// field width (clamped to MAX_FIELD_WIDTH and to 32) and the room left in
// bytes. The block answers on "text" with one ASCII byte per transfer,
// pad bytes first, then digits most significant first; last_char marks the
// final byte of a request. When room runs short the padding is cut first,
// then trailing digits; zero room gives no bytes at all. Per request the
// back end loads the request, runs the BCD conversion for decimal (four
// value bits per cycle through the double-dabble row; hex skips it), sizes
// the padding and digit count, then emits the bytes, stalling while the
// consumer holds ready low. The front end classifies requests into a
// two-entry queue, so new requests are taken while the back end is still
// converting or emitting, and a finished byte sits in an output register
// while the next is formed.
module integer_to_ascii_padded_top #(
    parameter int MAX_DIGITS      = 20,
    parameter int MAX_FIELD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    iap_in_if.sink    number,
    iap_out_if.source text
);
    import iap_pkg::*;

    logic     q_valid;
    logic     q_pop;
    iap_req_t q_req;

    // Accept and classify requests; hold them until the back end pops.
    iap_front #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .number  (number),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop)
    );

    // Convert to digits, size pad and digit runs, emit bytes.
    iap_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop),
        .text    (text)
    );

endmodule

`default_nettype wire
